// ----- src/pfa_pkg.sv -----
`timescale 1ns / 1ps
package pfa_pkg;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_EVICT = 2'd2,
        CMD_INIT  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STS_OK       = 2'd0,
        STS_NO_FREE  = 2'd1,
        STS_NO_BUSY  = 2'd2,
        STS_NOT_BUSY = 2'd3
    } status_t;

    typedef enum logic {
        REG_REGION_START = 1'b0,
        REG_REGION_END   = 1'b1
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC,
        ST_EVICT,
        ST_FREE_CHK,
        ST_FREE_APP,
        ST_INIT_RND,
        ST_INIT_CNT,
        ST_INIT_FILL
    } state_t;

endpackage

// ----- src/page_frame_allocator_fifo.sv -----
// Channel   Transfer condition             Signals
// command   start high while busy low      cmd, frame
// result    done high for one cycle        status, frame_out, page_number, free_count
// config    psel, penable, pwrite, pready  paddr, pwdata, prdata (word select paddr[2])
//
// Each command reads the link memories once as it is taken. Alloc and evict write back in
// their state; freeing a busy frame unlinks it, then appends it to the free list.
// Init writes one link entry per cycle in ST_INIT_FILL, N entries for a new pool of N.
// The result is registered from the command's last state and never held. Reset empties
// both lists and the pool; link memory data is only used once init has filled it.
`timescale 1ns / 1ps
module page_frame_allocator_fifo
    import pfa_pkg::*;
#(
    parameter int NUM_FRAMES = 256,
    parameter int PAGE_SHIFT = 12
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  cmd,
    input  logic [7:0]  frame,
    output logic        done,
    output logic [1:0]  status,
    output logic [7:0]  frame_out,
    output logic [19:0] page_number,
    output logic [8:0]  free_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(NUM_FRAMES);
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam logic [32:0] PAGE_MASK  = 33'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [32:0] FRAMES_MAX = 33'(NUM_FRAMES);

    state_t             state_reg, state_next;
    logic [7:0]         frame_reg, frame_next;
    logic [IDX_W-1:0]   free_head_reg, free_head_next;
    logic [IDX_W-1:0]   free_tail_reg, free_tail_next;
    logic [IDX_W-1:0]   busy_head_reg, busy_head_next;
    logic [IDX_W-1:0]   busy_tail_reg, busy_tail_next;
    logic [CNT_W-1:0]   free_total_reg, free_total_next;
    logic [CNT_W-1:0]   busy_total_reg, busy_total_next;
    logic [CNT_W-1:0]   pool_size_reg, pool_size_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic [19:0]        base_page_reg, base_page_next;
    logic [32:0]        rnd_reg, rnd_next;
    logic [31:0]        region_start_reg, region_end_reg;

    logic               done_reg, done_next;
    status_t            status_reg, status_next;
    logic [7:0]         frame_out_reg, frame_out_next;
    logic [19:0]        page_number_reg, page_number_next;
    logic [8:0]         free_count_reg, free_count_next;

    logic [IDX_W-1:0]   nxt_mem [NUM_FRAMES];
    logic [IDX_W:0]     prv_mem [NUM_FRAMES];
    logic [IDX_W-1:0]   nxt_rd_reg;
    logic [IDX_W:0]     prv_rd_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               nxt_we, prv_we;
    logic [IDX_W-1:0]   nxt_wa, nxt_wd, prv_wa;
    logic [IDX_W:0]     prv_wd;

    logic [IDX_W-1:0]   frm_idx, fill_idx, pg_idx;
    logic [19:0]        page_sel;
    logic               free_ok, fill_last;
    logic [33:0]        span;
    logic [32:0]        pages;
    logic [CNT_W-1:0]   init_pool;

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign frame_out   = frame_out_reg;
    assign page_number = page_number_reg;
    assign free_count  = free_count_reg;
    assign pready      = 1'b1;
    assign prdata      = paddr[2] ? region_end_reg : region_start_reg;

    assign frm_idx   = IDX_W'(frame_reg);
    assign fill_idx  = fill_reg[IDX_W-1:0];
    assign free_ok   = (32'(frame_reg) < 32'(pool_size_reg)) && prv_rd_reg[IDX_W];
    assign fill_last = ((fill_reg + CNT_W'(1)) == pool_size_reg);
    assign span      = 34'(region_end_reg) - 34'(rnd_reg);
    assign pages     = span[33] ? '0 : (span[32:0] >> PAGE_SHIFT);
    assign init_pool = (pages > FRAMES_MAX) ? CNT_W'(NUM_FRAMES) : CNT_W'(pages);
    assign page_sel  = base_page_reg + 20'(pg_idx);

    always_comb
    begin
        case (cmd_t'(cmd))
            CMD_FREE:  rd_addr = IDX_W'(frame);
            CMD_EVICT: rd_addr = busy_head_reg;
            default:   rd_addr = free_head_reg;
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_ALLOC:     pg_idx = free_head_reg;
            ST_EVICT:     pg_idx = busy_head_reg;
            ST_FREE_APP:  pg_idx = frm_idx;
            default:      pg_idx = '0;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd_t'(cmd))
                        CMD_ALLOC: state_next = ST_ALLOC;
                        CMD_FREE:  state_next = ST_FREE_CHK;
                        CMD_EVICT: state_next = ST_EVICT;
                        CMD_INIT:  state_next = ST_INIT_RND;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_ALLOC:     state_next = ST_IDLE;
            ST_EVICT:     state_next = ST_IDLE;
            ST_FREE_CHK:  state_next = free_ok ? ST_FREE_APP : ST_IDLE;
            ST_FREE_APP:  state_next = ST_IDLE;
            ST_INIT_RND:  state_next = ST_INIT_CNT;
            ST_INIT_CNT:  state_next = (init_pool == '0) ? ST_IDLE : ST_INIT_FILL;
            ST_INIT_FILL: state_next = fill_last ? ST_IDLE : ST_INIT_FILL;
            default:      state_next = ST_IDLE;
        endcase
    end

    // datapath and memory write-back
    always_comb
    begin
        frame_next       = frame_reg;
        free_head_next   = free_head_reg;
        free_tail_next   = free_tail_reg;
        busy_head_next   = busy_head_reg;
        busy_tail_next   = busy_tail_reg;
        free_total_next  = free_total_reg;
        busy_total_next  = busy_total_reg;
        pool_size_next   = pool_size_reg;
        fill_next        = fill_reg;
        base_page_next   = base_page_reg;
        rnd_next         = rnd_reg;
        done_next        = 1'b0;
        status_next      = status_reg;
        frame_out_next   = frame_out_reg;
        page_number_next = page_number_reg;
        free_count_next  = free_count_reg;
        nxt_we           = 1'b0;
        nxt_wa           = busy_tail_reg;
        nxt_wd           = free_head_reg;
        prv_we           = 1'b0;
        prv_wa           = free_head_reg;
        prv_wd           = {1'b1, busy_tail_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    frame_next = frame;
                end
            end

            ST_ALLOC:
            begin
                done_next = 1'b1;
                if (free_total_reg == '0)
                begin
                    status_next      = STS_NO_FREE;
                    frame_out_next   = '0;
                    page_number_next = '0;
                    free_count_next  = 9'(free_total_reg);
                end
                else
                begin
                    free_total_next = free_total_reg - CNT_W'(1);
                    if (free_total_reg == CNT_W'(1))
                    begin
                        free_head_next = '0;
                        free_tail_next = '0;
                    end
                    else
                    begin
                        free_head_next = nxt_rd_reg;
                    end
                    if (busy_total_reg != '0)
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = busy_tail_reg;
                        nxt_wd = free_head_reg;
                    end
                    else
                    begin
                        busy_head_next = free_head_reg;
                    end
                    prv_we           = 1'b1;
                    prv_wa           = free_head_reg;
                    prv_wd           = {1'b1, busy_tail_reg};
                    busy_tail_next   = free_head_reg;
                    busy_total_next  = busy_total_reg + CNT_W'(1);
                    status_next      = STS_OK;
                    frame_out_next   = 8'(free_head_reg);
                    page_number_next = page_sel;
                    free_count_next  = 9'(free_total_next);
                end
            end

            ST_EVICT:
            begin
                done_next       = 1'b1;
                free_count_next = 9'(free_total_reg);
                if (busy_total_reg == '0)
                begin
                    status_next      = STS_NO_BUSY;
                    frame_out_next   = '0;
                    page_number_next = '0;
                end
                else
                begin
                    // rotate oldest to the tail
                    if (busy_total_reg != CNT_W'(1))
                    begin
                        busy_head_next = nxt_rd_reg;
                        busy_tail_next = busy_head_reg;
                        nxt_we         = 1'b1;
                        nxt_wa         = busy_tail_reg;
                        nxt_wd         = busy_head_reg;
                        prv_we         = 1'b1;
                        prv_wa         = busy_head_reg;
                        prv_wd         = {1'b1, busy_tail_reg};
                    end
                    status_next      = STS_OK;
                    frame_out_next   = 8'(busy_head_reg);
                    page_number_next = page_sel;
                end
            end

            ST_FREE_CHK:
            begin
                if (!free_ok)
                begin
                    done_next        = 1'b1;
                    status_next      = STS_NOT_BUSY;
                    frame_out_next   = frame_reg;
                    page_number_next = '0;
                    free_count_next  = 9'(free_total_reg);
                end
                else
                begin
                    // unlink from the busy list
                    busy_total_next = busy_total_reg - CNT_W'(1);
                    if (busy_total_reg == CNT_W'(1))
                    begin
                        busy_head_next = '0;
                        busy_tail_next = '0;
                    end
                    else if (frm_idx == busy_head_reg)
                    begin
                        busy_head_next = nxt_rd_reg;
                    end
                    else if (frm_idx == busy_tail_reg)
                    begin
                        busy_tail_next = prv_rd_reg[IDX_W-1:0];
                    end
                    else
                    begin
                        nxt_we = 1'b1;
                        nxt_wa = prv_rd_reg[IDX_W-1:0];
                        nxt_wd = nxt_rd_reg;
                        prv_we = 1'b1;
                        prv_wa = nxt_rd_reg;
                        prv_wd = {1'b1, prv_rd_reg[IDX_W-1:0]};
                    end
                end
            end

            ST_FREE_APP:
            begin
                // append to the free tail
                if (free_total_reg == '0)
                begin
                    free_head_next = frm_idx;
                end
                else
                begin
                    nxt_we = 1'b1;
                    nxt_wa = free_tail_reg;
                    nxt_wd = frm_idx;
                end
                prv_we           = 1'b1;
                prv_wa           = frm_idx;
                prv_wd           = '0;
                free_tail_next   = frm_idx;
                free_total_next  = free_total_reg + CNT_W'(1);
                done_next        = 1'b1;
                status_next      = STS_OK;
                frame_out_next   = frame_reg;
                page_number_next = page_sel;
                free_count_next  = 9'(free_total_next);
            end

            ST_INIT_RND:
            begin
                rnd_next = (33'(region_start_reg) + PAGE_MASK) & ~PAGE_MASK;
            end

            ST_INIT_CNT:
            begin
                base_page_next  = 20'(rnd_reg >> PAGE_SHIFT);
                pool_size_next  = init_pool;
                free_head_next  = '0;
                free_tail_next  = (init_pool == '0) ? '0 : IDX_W'(init_pool - CNT_W'(1));
                busy_head_next  = '0;
                busy_tail_next  = '0;
                free_total_next = init_pool;
                busy_total_next = '0;
                fill_next       = '0;
                if (init_pool == '0)
                begin
                    done_next        = 1'b1;
                    status_next      = STS_OK;
                    frame_out_next   = '0;
                    page_number_next = base_page_next;
                    free_count_next  = '0;
                end
            end

            ST_INIT_FILL:
            begin
                nxt_we    = 1'b1;
                nxt_wa    = fill_idx;
                nxt_wd    = fill_idx + IDX_W'(1);
                prv_we    = 1'b1;
                prv_wa    = fill_idx;
                prv_wd    = '0;
                fill_next = fill_reg + CNT_W'(1);
                if (fill_last)
                begin
                    done_next        = 1'b1;
                    status_next      = STS_OK;
                    frame_out_next   = '0;
                    page_number_next = base_page_reg;
                    free_count_next  = 9'(pool_size_reg);
                end
            end

            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_head_reg  <= '0;
            free_tail_reg  <= '0;
            busy_head_reg  <= '0;
            busy_tail_reg  <= '0;
            free_total_reg <= '0;
            busy_total_reg <= '0;
            pool_size_reg  <= '0;
            fill_reg       <= '0;
            base_page_reg  <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            free_tail_reg  <= free_tail_next;
            busy_head_reg  <= busy_head_next;
            busy_tail_reg  <= busy_tail_next;
            free_total_reg <= free_total_next;
            busy_total_reg <= busy_total_next;
            pool_size_reg  <= pool_size_next;
            fill_reg       <= fill_next;
            base_page_reg  <= base_page_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frame_reg       <= frame_next;
        rnd_reg         <= rnd_next;
        status_reg      <= status_next;
        frame_out_reg   <= frame_out_next;
        page_number_reg <= page_number_next;
        free_count_reg  <= free_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_end_reg   <= '0;
        end
        else if (psel && penable && pwrite && pready)
        begin
            case (reg_idx_t'(paddr[2]))
                REG_REGION_START: region_start_reg <= pwdata;
                REG_REGION_END:   region_end_reg   <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        nxt_rd_reg <= nxt_mem[rd_addr];
        if (nxt_we)
        begin
            nxt_mem[nxt_wa] <= nxt_wd;
        end
    end

    always_ff @(posedge clk)
    begin
        prv_rd_reg <= prv_mem[rd_addr];
        if (prv_we)
        begin
            prv_mem[prv_wa] <= prv_wd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (32'(free_total_reg) + 32'(busy_total_reg)) <= 32'(pool_size_reg))
        else $error("free and busy counts exceed pool size");

    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) != ST_IDLE))
        else $error("result strobe without a command in progress");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command transfer did not raise busy");

    a_no_free_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == STS_NO_FREE)) |-> (free_count_reg == '0))
        else $error("alloc rejected while free frames remain");

endmodule
